// ===== design/swr_pkg.sv =====
// swr_pkg: shared constants, widths and controller/datapath command types
// for the sliding window rms block; no dependencies
package swr_pkg;

    // sample and window geometry
    localparam int SAMPLE_BITS   = 16;
    localparam int WINDOW_MAX    = 1024;
    localparam int PTR_BITS      = $clog2(WINDOW_MAX);
    localparam int LEN_BITS      = PTR_BITS + 1;
    localparam int CFG_LEN_BITS  = 11;
    localparam int WINDOW_RESET  = 32;

    // arithmetic widths
    localparam int SQ_BITS       = 2 * SAMPLE_BITS;
    localparam int SUM_BITS      = 2 * SAMPLE_BITS - 1 + PTR_BITS;
    localparam int RMS_BITS      = 16;
    localparam int ROOT_TOP      = ((SUM_BITS - 1) / 2) * 2;
    localparam int ROOT_STEPS    = ROOT_TOP / 2 + 1;
    localparam int STEP_BITS     = $clog2(SUM_BITS + 1);

    // apb register map
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
    localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LENGTH = '0;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic accept;
        logic sq_old;
        logic sq_new;
        logic update;
        logic div_step;
        logic root_init;
        logic root_step;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

// ===== design/swr_if.sv =====
// swr_if: valid/ready channels for sample input beats and rms result beats
// depends on swr_pkg
interface swr_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [swr_pkg::SAMPLE_BITS-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swr_rms_if;
    logic                              valid;
    logic                              ready;
    logic [swr_pkg::RMS_BITS-1:0]      rms_value;

    modport source (output valid, output rms_value, input ready);
    modport sink   (input valid, input rms_value, output ready);
endinterface

// ===== design/swr_ram.sv =====
// swr_ram: generic single write port, single read port ram with registered read
// no dependencies
module swr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and read-old-data registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/swr_ctrl.sv =====
// swr_ctrl: sequencer for one sample: squares, sum update, divide, root, output
// depends on swr_pkg
module swr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  swr_pkg::t_dp_status  i_status,
    output swr_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_OLD,
        S_SQ_NEW,
        S_UPDATE,
        S_DIVIDE,
        S_ROOT_INIT,
        S_ROOT,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [swr_pkg::STEP_BITS-1:0]   r_count, n_count;
    logic                            w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    // next state and step count
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SQ_OLD;
                end
            end
            S_SQ_OLD: begin
                n_state = S_SQ_NEW;
            end
            S_SQ_NEW: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_DIVIDE;
                n_count = '0;
            end
            S_DIVIDE: begin
                if (r_count == swr_pkg::STEP_BITS'(swr_pkg::SUM_BITS - 1)) begin
                    n_state = S_ROOT_INIT;
                end
                n_count = r_count + 1'b1;
            end
            S_ROOT_INIT: begin
                n_state = S_ROOT;
                n_count = '0;
            end
            S_ROOT: begin
                if (r_count == swr_pkg::STEP_BITS'(swr_pkg::ROOT_STEPS - 1)) begin
                    n_state = S_DONE;
                end
                n_count = r_count + 1'b1;
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.clear     = i_clear;
        o_cmd.accept    = w_accept;
        o_cmd.sq_old    = (r_state == S_SQ_OLD);
        o_cmd.sq_new    = (r_state == S_SQ_NEW);
        o_cmd.update    = (r_state == S_UPDATE);
        o_cmd.div_step  = (r_state == S_DIVIDE);
        o_cmd.root_init = (r_state == S_ROOT_INIT);
        o_cmd.root_step = (r_state == S_ROOT);
        o_cmd.load_out  = (r_state == S_DONE) && !i_status.out_busy;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/swr_datapath.sv =====
// swr_datapath: sample ring, running sum of squares, restoring divider,
// bit-serial square root and output register; depends on swr_pkg, swr_ram
module swr_datapath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  swr_pkg::t_dp_cmd                        i_cmd,
    input  logic signed [swr_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  logic [swr_pkg::LEN_BITS-1:0]            i_window_len,
    output swr_pkg::t_dp_status                     o_status,
    output logic                                    o_rms_valid,
    output logic [swr_pkg::RMS_BITS-1:0]            o_rms_value,
    input  logic                                    i_rms_ready
);

    localparam int SB = swr_pkg::SAMPLE_BITS;
    localparam int PB = swr_pkg::PTR_BITS;
    localparam int LB = swr_pkg::LEN_BITS;
    localparam int UB = swr_pkg::SUM_BITS;

    logic [PB-1:0]           r_ptr;
    logic [LB-1:0]           r_fill;
    logic [UB-1:0]           r_sum;
    logic                    r_old_valid;
    logic signed [SB-1:0]    r_sample;
    logic [UB-1:0]           r_sq_old;
    logic [UB-1:0]           r_sq_new;
    logic [UB-1:0]           r_quo;
    logic [LB-1:0]           r_rem;
    logic [UB-1:0]           r_res;
    logic [UB-1:0]           r_bit;
    logic                    r_out_valid;
    logic [swr_pkg::RMS_BITS-1:0] r_rms;

    logic [PB-1:0]                     w_old_idx;
    logic [SB-1:0]                     w_rdata;
    logic signed [SB-1:0]              w_mul_a;
    logic signed [swr_pkg::SQ_BITS-1:0] w_prod;
    logic [UB-1:0]                     w_square;
    logic [UB-1:0]                     w_new_sum;
    logic [LB:0]                       w_rem_sh;
    logic                              w_q_bit;
    logic [UB:0]                       w_trial;
    logic                              w_root_fit;

    // ring of past samples, oldest slot read while the new one is written
    assign w_old_idx = r_ptr - i_window_len[PB-1:0];

    swr_ram #(
        .WIDTH (SB),
        .DEPTH (swr_pkg::WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_ptr),
        .i_wdata (i_sample),
        .i_raddr (w_old_idx),
        .o_rdata (w_rdata)
    );

    // shared squarer: leaving sample (zero if never written) or new sample
    assign w_mul_a  = i_cmd.sq_new ? r_sample
                    : (r_old_valid ? $signed(w_rdata) : '0);
    assign w_prod   = w_mul_a * w_mul_a;
    assign w_square = UB'(unsigned'(w_prod));

    assign w_new_sum = r_sum + r_sq_new;

    // restoring divide step, one quotient bit
    assign w_rem_sh = {r_rem, r_quo[UB-1]};
    assign w_q_bit  = (w_rem_sh >= {1'b0, i_window_len});

    // square root step, one result bit
    assign w_trial    = {1'b0, r_res} + {1'b0, r_bit};
    assign w_root_fit = ({1'b0, r_quo} >= w_trial);

    // history state: pointer, fill count, running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_ptr  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_ptr <= r_ptr + 1'b1;
                if (r_fill < LB'(swr_pkg::WINDOW_MAX)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.sq_new) begin
                r_sum <= r_sum - r_sq_old;
            end
            if (i_cmd.update) begin
                r_sum <= w_new_sum;
            end
        end
    end

    // arithmetic working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample    <= i_sample;
            r_old_valid <= (r_fill >= i_window_len);
        end
        if (i_cmd.sq_old) begin
            r_sq_old <= w_square;
        end
        if (i_cmd.sq_new) begin
            r_sq_new <= w_square;
        end
        if (i_cmd.update) begin
            r_quo <= w_new_sum;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[UB-2:0], w_q_bit};
            r_rem <= w_q_bit ? LB'(w_rem_sh - {1'b0, i_window_len}) : w_rem_sh[LB-1:0];
        end
        if (i_cmd.root_init) begin
            r_res <= '0;
            r_bit <= UB'(1) << swr_pkg::ROOT_TOP;
        end
        if (i_cmd.root_step) begin
            if (w_root_fit) begin
                r_quo <= r_quo - w_trial[UB-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.load_out) begin
            r_rms <= r_res[swr_pkg::RMS_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_rms_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_rms_ready;
    assign o_rms_valid       = r_out_valid;
    assign o_rms_value       = r_rms;

endmodule

// ===== design/sliding_window_rms.sv =====
// sliding_window_rms: top level, apb window length register, controller
// and datapath; depends on swr_pkg, swr_if, swr_ctrl, swr_datapath
//
// One signed sample per input beat gives one result beat: the floor of the
// square root of the windowed sum of squares divided (floored) by the window
// length. A new sample is taken only after the last one is through: the
// controller reads the leaving sample and updates the running sum, runs the
// one-bit-per-cycle restoring divider and the one-bit-per-cycle square root,
// and loads the output register once the previous result has been taken.
// A finished result waits in the output register while the next sample is
// taken. Any write to window_length (address 0) restarts the observation
// with all slots counting as zero; length 0 acts as 1 and lengths above
// 1024 act as 1024. Write configuration only while no sample is in flight.
module sliding_window_rms (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    swr_sample_if.sink                          i_in,
    swr_rms_if.source                           o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swr_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [swr_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [swr_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    logic [swr_pkg::CFG_LEN_BITS-1:0]  r_window_length;
    logic [swr_pkg::REG_IDX_BITS-1:0]  w_reg_idx;
    logic                              w_cfg_write;
    logic [swr_pkg::LEN_BITS-1:0]      w_eff_len;
    swr_pkg::t_dp_cmd                  w_cmd;
    swr_pkg::t_dp_status               w_status;

    // apb register access
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[swr_pkg::APB_ADDR_BITS-1:2];

    always_comb begin
        w_cfg_write = 1'b0;
        prdata      = '0;
        unique case (w_reg_idx)
            swr_pkg::REG_WINDOW_LENGTH: begin
                w_cfg_write = psel && penable && pwrite;
                prdata      = swr_pkg::APB_DATA_BITS'(r_window_length);
            end
            default: begin
                w_cfg_write = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= swr_pkg::CFG_LEN_BITS'(swr_pkg::WINDOW_RESET);
        end else if (w_cfg_write) begin
            r_window_length <= pwdata[swr_pkg::CFG_LEN_BITS-1:0];
        end
    end

    // clamp window length to 1..WINDOW_MAX
    always_comb begin
        if (r_window_length == '0) begin
            w_eff_len = swr_pkg::LEN_BITS'(1);
        end else if (32'(r_window_length) > 32'(swr_pkg::WINDOW_MAX)) begin
            w_eff_len = swr_pkg::LEN_BITS'(swr_pkg::WINDOW_MAX);
        end else begin
            w_eff_len = swr_pkg::LEN_BITS'(r_window_length);
        end
    end

    swr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_cfg_write),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    swr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_sample     (i_in.sample),
        .i_window_len (w_eff_len),
        .o_status     (w_status),
        .o_rms_valid  (o_out.valid),
        .o_rms_value  (o_out.rms_value),
        .i_rms_ready  (o_out.ready)
    );

endmodule

// ===== design/swr_checker.sv =====
// swr_checker: port-level checks for sliding_window_rms, bound to the top
// depends on swr_pkg
module swr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [swr_pkg::RMS_BITS-1:0]   i_rms_value
);

    // one sample at a time: ready drops after an accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a sample is in flight");

    // a result never appears the cycle after its sample is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared without computation");

    // rms of 16-bit samples never exceeds full scale
    a_rms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_rms_value <= swr_pkg::RMS_BITS'(32768))
        else $error("rms value out of range");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rms_value))
        else $error("stalled result beat changed");

endmodule

bind sliding_window_rms swr_checker u_swr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rms_value (o_out.rms_value)
);

// ===== tb/sliding_window_rms_check.sv =====
// sliding_window_rms_check: watches the sample, rms and apb channels, keeps its
// own copy of the window and compares every rms beat against it
// depends on swr_pkg and swr_if
module sliding_window_rms_check
    import swr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    swr_sample_if                       i_smp,
    swr_rms_if                          i_rms,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_BITS-1:0]    paddr,
    input  logic [APB_DATA_BITS-1:0]    pwdata,
    input  logic                        pready,
    output int                          o_mismatch_count,
    output int                          o_rms_pending
);

    // window history, running energy and length setting
    logic signed [SAMPLE_BITS-1:0] window_ring [WINDOW_MAX];
    logic [SUM_BITS-1:0]           energy_sum;
    logic [PTR_BITS-1:0]           next_slot;
    logic [CFG_LEN_BITS-1:0]       window_len;

    // rms values still owed by the block, oldest first
    logic [RMS_BITS-1:0]           rms_due [$];
    int                            mismatches = 0;

    assign o_mismatch_count = mismatches;

    task automatic report_mismatch(input string what, input logic [RMS_BITS-1:0] got,
                                   input logic [RMS_BITS-1:0] want);
        $display("mismatch: %s, got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic clear_window();
        foreach (window_ring[i]) window_ring[i] = '0;
        energy_sum = '0;
        next_slot  = '0;
    endtask

    function automatic longint unsigned sample_energy(input logic signed [SAMPLE_BITS-1:0] s);
        longint v;
        v = longint'(s);
        return v * v;
    endfunction

    // bit-by-bit floor square root; the sum stays below 2^41 so 21 root bits do
    function automatic logic [RMS_BITS-1:0] floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return RMS_BITS'(r);
    endfunction

    // push one sample into the window and work out the new rms
    task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] s,
                               output logic [RMS_BITS-1:0] rms);
        longint unsigned     span;
        longint unsigned     sum;
        logic [PTR_BITS-1:0] leaving;
        if (window_len == 0) begin
            span = 1;
        end else if (window_len > WINDOW_MAX) begin
            span = WINDOW_MAX;
        end else begin
            span = window_len;
        end
        // slot that drops out; a full-size window wraps onto the slot being written
        leaving = next_slot - PTR_BITS'(span);
        sum = energy_sum;
        sum = sum - sample_energy(window_ring[leaving]) + sample_energy(s);
        energy_sum = SUM_BITS'(sum);
        window_ring[next_slot] = s;
        next_slot = next_slot + 1'b1;
        rms = floor_root(sum / span);
    endtask

    always @(posedge i_clk) begin : track
        logic [RMS_BITS-1:0] rms;
        if (!i_rst_n) begin
            clear_window();
            window_len = CFG_LEN_BITS'(WINDOW_RESET);
            rms_due.delete();
        end else begin
            // any write to the length register restarts the observation
            if (psel && penable && pwrite && pready &&
                paddr[APB_ADDR_BITS-1:2] == REG_WINDOW_LENGTH) begin
                window_len = pwdata[CFG_LEN_BITS-1:0];
                clear_window();
            end
            // sample beat
            if (i_smp.valid && i_smp.ready) begin
                take_sample(i_smp.sample, rms);
                rms_due.push_back(rms);
            end
            // rms beat
            if (i_rms.valid && i_rms.ready) begin
                if (rms_due.size() == 0) begin
                    report_mismatch("rms beat with nothing owed", i_rms.rms_value, '0);
                end else begin
                    rms = rms_due.pop_front();
                    if (i_rms.rms_value !== rms)
                        report_mismatch("rms_value", i_rms.rms_value, rms);
                end
            end
        end
        o_rms_pending = rms_due.size();
    end

endmodule

// ===== tb/sliding_window_rms_tb.sv =====
// sliding_window_rms_tb: drives samples and window length writes into the
// sliding window rms block and gives the verdict from the checker's count
// depends on swr_pkg, swr_if, sliding_window_rms and sliding_window_rms_check
module sliding_window_rms_tb;
    import swr_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_GAP    = 80;
    localparam int EDGE_COUNT   = 8;
    localparam int PHASES       = 8;
    localparam int RANDOM_TOTAL = 1360;

    localparam logic [REG_IDX_BITS-1:0]  REG_UNMAPPED = REG_WINDOW_LENGTH + 1'b1;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW_LENGTH = {REG_WINDOW_LENGTH, 2'b00};
    localparam logic [APB_ADDR_BITS-1:0] ADDR_UNMAPPED      = {REG_UNMAPPED, 2'b00};

    localparam logic signed [SAMPLE_BITS-1:0] EDGE_SAMPLES [EDGE_COUNT] = '{
        16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
        16'sh0001, 16'sh5555, 16'shAAAA, 16'sh8000
    };

    // window lengths for the random phases and beats sent in each
    localparam int unsigned PHASE_LEN [PHASES]   = '{32, 3, 1, 1023, 0, 2047, 1024, 1024};
    localparam int          PHASE_ITEMS [PHASES] = '{40, 60, 40, 1040, 30, 40, 60, 50};

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    int mismatch_count;
    int rms_pending;
    int cycles       = 0;
    int random_sent  = 0;
    int src_idle_pct = 14;
    int snk_idle_pct = 80;

    swr_sample_if smp_ch ();
    swr_rms_if    rms_ch ();

    sliding_window_rms u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp_ch),
        .o_out   (rms_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sliding_window_rms_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_smp            (smp_ch),
        .i_rms            (rms_ch),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .o_mismatch_count (mismatch_count),
        .o_rms_pending    (rms_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // rms receiver stalls
    always @(negedge i_clk) begin
        rms_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
    endtask

    // hold samples back until every owed rms beat is out, then settle
    task automatic wait_drained(input int settle);
        @(negedge i_clk);
        smp_ch.valid <= 1'b0;
        while (rms_pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // idle pattern by progress: sender light, then receiver light, then none
    task automatic pick_idle_mode();
        if (random_sent < RANDOM_TOTAL / 3) begin
            src_idle_pct = 14;
            snk_idle_pct = 80;
        end else if (random_sent < 2 * RANDOM_TOTAL / 3) begin
            src_idle_pct = 80;
            snk_idle_pct = 14;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
    endtask

    // mix of full-range, edge, near-zero and large-amplitude samples
    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        logic signed [SAMPLE_BITS-1:0] s;
        int unsigned                   pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            s = SAMPLE_BITS'($urandom);
        end else if (pick < 60) begin
            s = EDGE_SAMPLES[$urandom_range(EDGE_COUNT - 1)];
        end else if (pick < 85) begin
            s = SAMPLE_BITS'($urandom_range(511)) - SAMPLE_BITS'(256);
        end else begin
            s = SAMPLE_BITS'($urandom_range(32767));
            if ($urandom_range(1) == 1) s = -s;
        end
        return s;
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // edge samples at the reset length
        foreach (EDGE_SAMPLES[i]) push_sample(EDGE_SAMPLES[i]);

        // length 1 with junk in the upper data bits: full-scale negative gives 32768
        wait_drained(DRAIN_GAP);
        cfg_write(ADDR_WINDOW_LENGTH, 32'hFFFF_F801);
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        push_sample(16'sh0000);
        push_sample(16'shFFFF);

        // zero length acts as one
        wait_drained(DRAIN_GAP);
        cfg_write(ADDR_WINDOW_LENGTH, 32'd0);
        push_sample(16'sh8000);
        push_sample(16'sh0005);

        // largest setting acts as the full window
        wait_drained(DRAIN_GAP);
        cfg_write(ADDR_WINDOW_LENGTH, 32'd2047);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);

        // write past the register list leaves length and history alone
        wait_drained(DRAIN_GAP);
        cfg_write(ADDR_UNMAPPED, 32'd7);
        push_sample(16'sh8000);
        push_sample(16'sh0064);

        // random phases, one window length each
        for (int p = 0; p < PHASES; p++) begin
            wait_drained(DRAIN_GAP);
            cfg_write(ADDR_WINDOW_LENGTH, PHASE_LEN[p]);
            repeat (PHASE_ITEMS[p]) begin
                pick_idle_mode();
                if ($urandom_range(199) == 0) wait_drained(0);
                push_sample(random_sample());
                random_sent++;
            end
        end

        wait_drained(DRAIN_GAP);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/swr_pkg.sv
design/swr_if.sv
design/swr_ram.sv
design/swr_ctrl.sv
design/swr_datapath.sv
design/sliding_window_rms.sv
design/swr_checker.sv
tb/sliding_window_rms_check.sv
tb/sliding_window_rms_tb.sv
